@@ rtl/core/lfu_cache_table_unit_defines.svh @@
// Assertion macros for the LFU table. The enclosing module supplies clk and arst_n.
`ifndef LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`define LFU_CACHE_TABLE_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lfu_pkg.sv @@
package lfu_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 48;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// APB register map: one register, decoded on the word address bit.
	localparam int PADDR_W = 3;
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

@@ rtl/core/lfu_cache_table_unit.sv @@
// Fully associative key/value table with least-frequently-used replacement and an
// oldest-first tie break. Each transfer on the input channel is one get or put; it
// produces exactly one result transfer. Each entry is read in turn through the
// single read port of the entry memory, and the registered read data feeds one
// shared key compare and count/stamp compare unit. The touched or inserted entry
// is then written back in the same cycle as the result register is loaded, and
// the sequencer returns to idle before a new item is taken. The input stalls
// while an item is being worked on, and the write-back waits while an earlier
// result is still stalled in the output register; a finished result waits in the
// output register while the next item is already scanning. The capacity register
// (address 0) may only be written while the table is idle.
`include "lfu_cache_table_unit_defines.svh"

module lfu_cache_table_unit #(
	parameter int DEPTH = lfu_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lfu_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic signed [lfu_pkg::DATA_W-1:0]  key,
	input  logic signed [lfu_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic signed [lfu_pkg::DATA_W-1:0]  read_value,
	output logic                               evicted,
	output logic signed [lfu_pkg::DATA_W-1:0]  evicted_key
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW    = lfu_pkg::DATA_W;
	localparam int CW    = lfu_pkg::COUNT_W;
	localparam int SW    = lfu_pkg::STAMP_W;

	lfu_pkg::state_t state_q, state_d;

	logic [lfu_pkg::CAP_W-1:0] capacity_q;

	// Entry storage.
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    key_mem   [DEPTH];
	logic [DW-1:0]    value_mem [DEPTH];
	logic [CW-1:0]    count_mem [DEPTH];
	logic [SW-1:0]    stamp_mem [DEPTH];

	logic [SW-1:0] access_stamp_q;

	// Latched item.
	logic          cmd_q;
	logic [DW-1:0] key_q;
	logic [DW-1:0] value_q;

	// Scan read port and compare stage.
	logic [CNT_W-1:0] scan_cnt_q;
	logic             issue;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [DW-1:0]    rd_key_s1;
	logic [DW-1:0]    rd_value_s1;
	logic [CW-1:0]    rd_count_s1;
	logic [SW-1:0]    rd_stamp_s1;
	logic             scan_last;

	// Scan results.
	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic [DW-1:0]    hit_value_q;
	logic [CW-1:0]    hit_count_q;
	logic [CNT_W-1:0] used_q;
	logic             have_free_q;
	logic [IDX_W-1:0] free_q;
	logic             any_q;
	logic [IDX_W-1:0] vic_q;
	logic [CW-1:0]    vic_count_q;
	logic [SW-1:0]    vic_stamp_q;
	logic [DW-1:0]    vic_key_q;

	// Result register.
	logic          out_valid_q;
	logic          hit_q;
	logic [DW-1:0] read_value_q;
	logic          evicted_q;
	logic [DW-1:0] evicted_key_q;

	logic          in_xfer;
	logic          out_xfer;
	logic          cfg_write;
	logic          upd_go;
	logic          is_put;
	logic [31:0]   cap_ext;
	logic [31:0]   cap_eff;
	logic          cap_zero;
	logic          full;
	logic          need_evict;
	logic          do_touch;
	logic          do_insert;
	logic [IDX_W-1:0] dst;
	logic [CW-1:0] touched_count;
	logic          cur_valid;
	logic          better_victim;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == lfu_pkg::REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_write && paddr[2] == lfu_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[lfu_pkg::CAP_W-1:0];
		end
	end

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = lfu_pkg::ST_UPDATE;
				end
			end
			lfu_pkg::ST_UPDATE: begin
				if (upd_go) begin
					state_d = lfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
	end

	// Entry scan: one memory read per cycle, compared in the following cycle.
	assign issue     = (state_q == lfu_pkg::ST_SCAN) && (scan_cnt_q < CNT_W'(DEPTH));
	assign scan_last = valid_s1 && (idx_s1 == IDX_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (in_xfer) begin
				scan_cnt_q <= '0;
			end else if (issue) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1      <= scan_cnt_q[IDX_W-1:0];
			rd_key_s1   <= key_mem[scan_cnt_q[IDX_W-1:0]];
			rd_value_s1 <= value_mem[scan_cnt_q[IDX_W-1:0]];
			rd_count_s1 <= count_mem[scan_cnt_q[IDX_W-1:0]];
			rd_stamp_s1 <= stamp_mem[scan_cnt_q[IDX_W-1:0]];
		end
	end

	assign cur_valid = valid_q[idx_s1];

	// Lowest count wins, then the oldest stamp; a strict compare keeps the lower slot on a tie.
	assign better_victim = !any_q || (rd_count_s1 < vic_count_q) ||
		((rd_count_s1 == vic_count_q) && (rd_stamp_s1 < vic_stamp_q));

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			found_q     <= 1'b0;
			used_q      <= '0;
			have_free_q <= 1'b0;
			any_q       <= 1'b0;
		end else if (valid_s1) begin
			if (cur_valid) begin
				used_q <= used_q + CNT_W'(1);
				if (!found_q && rd_key_s1 == key_q) begin
					found_q     <= 1'b1;
					slot_q      <= idx_s1;
					hit_value_q <= rd_value_s1;
					hit_count_q <= rd_count_s1;
				end
				if (better_victim) begin
					any_q       <= 1'b1;
					vic_q       <= idx_s1;
					vic_count_q <= rd_count_s1;
					vic_stamp_q <= rd_stamp_s1;
					vic_key_q   <= rd_key_s1;
				end
			end else if (!have_free_q) begin
				have_free_q <= 1'b1;
				free_q      <= idx_s1;
			end
		end
	end

	// Write-back decision.
	assign is_put     = (cmd_q == lfu_pkg::CMD_PUT);
	assign cap_ext    = 32'(capacity_q);
	assign cap_eff    = (cap_ext > 32'(DEPTH)) ? 32'(DEPTH) : cap_ext;
	assign cap_zero   = (cap_eff == 32'd0);
	assign full       = (32'(used_q) >= cap_eff);
	assign need_evict = (full || !have_free_q) && any_q;
	assign dst        = need_evict ? vic_q : free_q;
	assign do_touch   = found_q && (!is_put || !cap_zero);
	assign do_insert  = is_put && !cap_zero && !found_q;
	assign touched_count = (hit_count_q == '1) ? hit_count_q : hit_count_q + CW'(1);

	// The result register must be free before the entry is written back.
	assign upd_go = (state_q == lfu_pkg::ST_UPDATE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (upd_go && do_touch) begin
			count_mem[slot_q] <= touched_count;
			stamp_mem[slot_q] <= access_stamp_q;
			if (is_put) begin
				value_mem[slot_q] <= value_q;
			end
		end else if (upd_go && do_insert) begin
			key_mem[dst]   <= key_q;
			value_mem[dst] <= value_q;
			count_mem[dst] <= CW'(1);
			stamp_mem[dst] <= access_stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			access_stamp_q <= '0;
		end else if (upd_go && (do_touch || do_insert)) begin
			access_stamp_q <= access_stamp_q + SW'(1);
			if (do_insert) begin
				valid_q[dst] <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			hit_q         <= found_q;
			read_value_q  <= (!is_put && found_q) ? hit_value_q : '0;
			evicted_q     <= do_insert && need_evict;
			evicted_key_q <= (do_insert && need_evict) ? vic_key_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	`LFU_ASSERT_NEXT(a_accept_starts_scan, in_xfer, state_q == lfu_pkg::ST_SCAN, "no scan")
	`LFU_ASSERT_NEXT(a_update_gives_result, upd_go, out_valid_q, "write-back without a result")
	`LFU_ASSERT_SAME(a_hit_evict_exclusive, out_valid_q, !(hit_q && evicted_q), "hit evicted")
	`LFU_ASSERT_SAME(a_miss_reads_zero, out_valid_q && !hit_q, read_value_q == '0, "miss value")

endmodule
